// ----- rtl/text_cell_buffer_editor_core_defines.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef TEXT_CELL_BUFFER_EDITOR_CORE_DEFINES_SVH
`define TEXT_CELL_BUFFER_EDITOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define TCBE_ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("tcbe assertion failed");
`define TCBE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("tcbe assertion failed");
`else
`define TCBE_ASSERT_SAME(lbl, ck, rn, ante, cons)
`define TCBE_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ----- rtl/tcbe_pkg.sv -----
`default_nettype none

package tcbe_pkg;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 6;
    localparam int CHAR_W = 8;
    localparam int CMD_W  = 2;
    localparam int UCOL_W = COL_W + 1;
    localparam int UROW_W = ROW_W + 1;

    localparam int MAX_COLS = 1 << COL_W;
    localparam int MAX_ROWS = 1 << ROW_W;
    localparam int CELLS    = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int TAB_STOP = 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS = 2'd1;
    localparam logic [UCOL_W-1:0] COLS_RESET = 8'd80;
    localparam logic [UROW_W-1:0] ROWS_RESET = 7'd25;

    localparam logic [CMD_W-1:0] CMD_TYPE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NAV  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    localparam logic [CHAR_W-1:0] KEY_UP     = 8'd0;
    localparam logic [CHAR_W-1:0] KEY_DOWN   = 8'd1;
    localparam logic [CHAR_W-1:0] KEY_LEFT   = 8'd2;
    localparam logic [CHAR_W-1:0] KEY_RIGHT  = 8'd3;
    localparam logic [CHAR_W-1:0] KEY_HOME   = 8'd4;
    localparam logic [CHAR_W-1:0] KEY_DELETE = 8'd5;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ESC   = 8'h1B;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } in_word_t;

    typedef struct packed {
        logic [COL_W-1:0]  caret_col;
        logic [ROW_W-1:0]  caret_row;
        logic [CHAR_W-1:0] cell_char;
    } out_word_t;

    typedef struct packed {
        logic              clear;
        logic [UCOL_W-1:0] cols;
        logic [UROW_W-1:0] rows;
    } eng_ctl_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return {row, col};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/text_cell_buffer_editor_core.sv -----
`default_nettype none
`include "text_cell_buffer_editor_core_defines.svh"

// Character-cell screen buffer with a caret, held in one 8192 x 8 cell memory with a
// single write port and a registered read port. Items are taken one at a time. A tab
// writes spaces up to the next tab stop (at most 8), and a delete or backspace moves
// the cells right of the caret (at most 127) left, since the row shift moves one cell
// per cycle through the memory. Escape walks the used rows one cell per cycle. After
// reset and after every size register write the whole memory is cleared, during which
// in_ready stays low; configuration writes are taken at any time. A result waiting in
// the output register does not block the next word from being accepted.
module text_cell_buffer_editor_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire tcbe_pkg::in_word_t                    in_word,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output tcbe_pkg::out_word_t                        out_word,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [tcbe_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [tcbe_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import tcbe_pkg::*;

    logic [UCOL_W-1:0] ucols_reg, ucols_next;
    logic [UROW_W-1:0] urows_reg, urows_next;
    logic [UROW_W-1:0] rows_raw;
    logic              cfg_take;
    logic              cfg_hit;
    logic              cfg_miss;
    eng_ctl_t          ctl;

    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_take && ((cfg_index == CFG_COLS) || (cfg_index == CFG_ROWS));
    assign cfg_miss  = cfg_take && !cfg_hit;
    assign rows_raw  = cfg_data[UROW_W-1:0];

    always_comb
    begin
        ucols_next = ucols_reg;
        urows_next = urows_reg;
        if (cfg_take && (cfg_index == CFG_COLS))
        begin
            if (cfg_data == '0)
            begin
                ucols_next = UCOL_W'(1);
            end
            else if ({1'b0, cfg_data} > 9'(MAX_COLS))
            begin
                ucols_next = UCOL_W'(MAX_COLS);
            end
            else
            begin
                ucols_next = cfg_data;
            end
        end
        if (cfg_take && (cfg_index == CFG_ROWS))
        begin
            if (rows_raw == '0)
            begin
                urows_next = UROW_W'(1);
            end
            else if (rows_raw > UROW_W'(MAX_ROWS))
            begin
                urows_next = UROW_W'(MAX_ROWS);
            end
            else
            begin
                urows_next = rows_raw;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ucols_reg <= COLS_RESET;
            urows_reg <= ROWS_RESET;
        end
        else
        begin
            ucols_reg <= ucols_next;
            urows_reg <= urows_next;
        end
    end

    assign ctl.clear = cfg_hit;
    assign ctl.cols  = ucols_reg;
    assign ctl.rows  = urows_reg;

    tcbe_edit u_edit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    `TCBE_ASSERT_NEXT(a_cfg_blocks_input, clk, rst_n, cfg_hit, !in_ready)
    `TCBE_ASSERT_NEXT(a_one_item_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
    `TCBE_ASSERT_NEXT(a_bad_index_keeps_size, clk, rst_n, cfg_miss, $stable({ucols_reg, urows_reg}))

endmodule

`default_nettype wire

// ----- rtl/tcbe_edit.sv -----
`default_nettype none

module tcbe_edit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tcbe_pkg::eng_ctl_t ctl,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire tcbe_pkg::in_word_t in_word,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output tcbe_pkg::out_word_t     out_word
);
    import tcbe_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_TAB,
        ST_DEL,
        ST_DEL_END,
        ST_RESP
    } state_t;

    state_t               state_reg,     state_next;
    in_word_t             item_reg,      item_next;
    logic [COL_W-1:0]     caret_x_reg,   caret_x_next;
    logic [ROW_W-1:0]     caret_y_reg,   caret_y_next;
    logic [CHAR_W-1:0]    cell_reg,      cell_next;
    logic [ADDR_W-1:0]    clr_addr_reg,  clr_addr_next;
    logic [ROW_W-1:0]     clr_last_reg,  clr_last_next;
    logic                 clr_resp_reg,  clr_resp_next;
    logic [UCOL_W-1:0]    dcol_reg,      dcol_next;
    logic                 pend_reg,      pend_next;
    logic                 out_valid_reg, out_valid_next;
    out_word_t            out_word_reg,  out_word_next;

    logic [CHAR_W-1:0]    cell_mem [CELLS];
    logic [CHAR_W-1:0]    rd_data_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [CHAR_W-1:0]    mem_wdata;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_raddr;

    logic [UCOL_W-1:0]    x_inc;
    logic [UROW_W-1:0]    y_inc;
    logic [ROW_W-1:0]     down_y;
    logic [COL_W-1:0]     adv_x;
    logic [ROW_W-1:0]     adv_y;
    logic [UCOL_W-1:0]    dcol_m2;
    logic [UCOL_W-1:0]    last_col;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_comb
    begin
        x_inc    = {1'b0, caret_x_reg} + UCOL_W'(1);
        y_inc    = {1'b0, caret_y_reg} + UROW_W'(1);
        down_y   = (y_inc >= ctl.rows) ? '0 : y_inc[ROW_W-1:0];
        adv_x    = (x_inc >= ctl.cols) ? '0 : x_inc[COL_W-1:0];
        adv_y    = (x_inc >= ctl.cols) ? down_y : caret_y_reg;
        dcol_m2  = dcol_reg - UCOL_W'(2);
        last_col = ctl.cols - UCOL_W'(1);
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        caret_x_next   = caret_x_reg;
        caret_y_next   = caret_y_reg;
        cell_next      = cell_reg;
        clr_addr_next  = clr_addr_reg;
        clr_last_next  = clr_last_reg;
        clr_resp_next  = clr_resp_reg;
        dcol_next      = dcol_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        mem_we         = 1'b0;
        mem_waddr      = cell_addr(caret_y_reg, caret_x_reg);
        mem_wdata      = CH_SPACE;
        mem_re         = 1'b0;
        mem_raddr      = cell_addr(caret_y_reg, caret_x_reg);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                if (clr_addr_reg == {clr_last_reg, {COL_W{1'b1}}})
                begin
                    state_next = clr_resp_reg ? ST_RESP : ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_word;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cell_next  = '0;
                state_next = ST_RESP;
                case (item_reg.cmd)
                    CMD_TYPE:
                    begin
                        case (item_reg.code)
                            CH_BS:
                            begin
                                if (caret_x_reg != '0)
                                begin
                                    caret_x_next = caret_x_reg - COL_W'(1);
                                    dcol_next    = {1'b0, caret_x_reg};
                                    pend_next    = 1'b0;
                                    state_next   = ST_DEL;
                                end
                            end
                            CH_TAB:
                            begin
                                state_next = ST_TAB;
                            end
                            CH_LF:
                            begin
                                caret_y_next = down_y;
                            end
                            CH_CR:
                            begin
                                caret_x_next = '0;
                                caret_y_next = down_y;
                            end
                            CH_ESC:
                            begin
                                caret_x_next  = '0;
                                caret_y_next  = '0;
                                clr_addr_next = '0;
                                clr_last_next = ROW_W'(ctl.rows - UROW_W'(1));
                                clr_resp_next = 1'b1;
                                state_next    = ST_CLEAR;
                            end
                            default:
                            begin
                                mem_we       = 1'b1;
                                mem_wdata    = item_reg.code;
                                caret_x_next = adv_x;
                                caret_y_next = adv_y;
                            end
                        endcase
                    end
                    CMD_NAV:
                    begin
                        case (item_reg.code)
                            KEY_UP:
                            begin
                                if (caret_y_reg != '0)
                                begin
                                    caret_y_next = caret_y_reg - ROW_W'(1);
                                end
                            end
                            KEY_DOWN:
                            begin
                                if (y_inc < ctl.rows)
                                begin
                                    caret_y_next = y_inc[ROW_W-1:0];
                                end
                            end
                            KEY_LEFT:
                            begin
                                if (caret_x_reg != '0)
                                begin
                                    caret_x_next = caret_x_reg - COL_W'(1);
                                end
                            end
                            KEY_RIGHT:
                            begin
                                if (x_inc < ctl.cols)
                                begin
                                    caret_x_next = x_inc[COL_W-1:0];
                                end
                            end
                            KEY_HOME:
                            begin
                                caret_x_next = '0;
                                caret_y_next = '0;
                            end
                            KEY_DELETE:
                            begin
                                dcol_next  = x_inc;
                                pend_next  = 1'b0;
                                state_next = ST_DEL;
                            end
                            default:
                            begin
                                state_next = ST_RESP;
                            end
                        endcase
                    end
                    CMD_READ:
                    begin
                        if (({1'b0, item_reg.read_row} < ctl.rows) &&
                            ({1'b0, item_reg.read_col} < ctl.cols))
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = cell_addr(item_reg.read_row, item_reg.read_col);
                            state_next = ST_READ;
                        end
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_READ:
            begin
                cell_next  = rd_data_reg;
                state_next = ST_RESP;
            end
            ST_TAB:
            begin
                mem_we       = 1'b1;
                caret_x_next = adv_x;
                caret_y_next = adv_y;
                if ((adv_x % COL_W'(TAB_STOP)) == '0)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_DEL:
            begin
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cell_addr(caret_y_reg, dcol_m2[COL_W-1:0]);
                    mem_wdata = rd_data_reg;
                end
                if (dcol_reg < ctl.cols)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = cell_addr(caret_y_reg, dcol_reg[COL_W-1:0]);
                    pend_next = 1'b1;
                    dcol_next = dcol_reg + UCOL_W'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_DEL_END;
                end
            end
            ST_DEL_END:
            begin
                mem_we     = 1'b1;
                mem_waddr  = cell_addr(caret_y_reg, last_col[COL_W-1:0]);
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next          = 1'b1;
                    out_word_next.caret_col = caret_x_reg;
                    out_word_next.caret_row = caret_y_reg;
                    out_word_next.cell_char = cell_reg;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ctl.clear)
        begin
            state_next    = ST_CLEAR;
            caret_x_next  = '0;
            caret_y_next  = '0;
            clr_addr_next = '0;
            clr_last_next = ROW_W'(MAX_ROWS - 1);
            clr_resp_next = 1'b0;
            pend_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            caret_x_reg   <= '0;
            caret_y_reg   <= '0;
            clr_addr_reg  <= '0;
            clr_last_reg  <= ROW_W'(MAX_ROWS - 1);
            clr_resp_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            caret_x_reg   <= caret_x_next;
            caret_y_reg   <= caret_y_next;
            clr_addr_reg  <= clr_addr_next;
            clr_last_reg  <= clr_last_next;
            clr_resp_reg  <= clr_resp_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        cell_reg     <= cell_next;
        dcol_reg     <= dcol_next;
        out_word_reg <= out_word_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= cell_mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire
